FILE: hw/rtl/ugbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugbp_pkg
// Shared types and constants of the uniform grid broad phase.
// ----------------------------------------------------------------------------
package ugbp_pkg;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_QCELL  = 2'd2,
		REQ_QNEAR  = 2'd3
	} req_t;

	localparam logic [2:0] CFG_WMIN_X = 3'd0;
	localparam logic [2:0] CFG_WMAX_X = 3'd1;
	localparam logic [2:0] CFG_WMIN_Z = 3'd2;
	localparam logic [2:0] CFG_WMAX_Z = 3'd3;
	localparam logic [2:0] CFG_CHUNK  = 3'd4;

	localparam logic [31:0] WMIN_RST  = 32'h0000_0000;
	localparam logic [31:0] WMAX_RST  = 32'h0400_0000;
	localparam logic [30:0] CHUNK_RST = 31'h0040_0000;

	// signed cell coordinate width; holds -15..127 for grids up to 64 cells
	localparam int CW     = 8;
	localparam int IDX_W  = 6;
	localparam int SAT_LO = -8;
	localparam int SAT_HI = 120;
	localparam int DIV_STEPS = 33;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic div_next;
		logic post;
		logic sweep_step;
		logic rd;
		logic ins_wr;
		logic scan_load;
		logic scan_step;
		logic loop_next;
		logic final_push;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic in_refuse;
		logic div_done;
		logic div_last;
		logic sweep_last;
		logic loop_empty;
		logic in_grid;
		logic scan_empty;
		logic out_free;
		logic pend_v;
		logic loop_last;
	} sts_t;

	// squeeze a wide quotient into the small cell coordinate range
	function automatic logic signed [CW-1:0] sat_cell(input logic signed [34:0] v);
		logic signed [CW-1:0] r;
		if (v < SAT_LO)
			r = CW'(SAT_LO);
		else if (v > SAT_HI)
			r = CW'(SAT_HI);
		else
			r = v[CW-1:0];
		return r;
	endfunction

endpackage

FILE: hw/rtl/ugbp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugbp_div
// Restoring divider, one quotient bit per cycle, 33 bit dividend.
// ----------------------------------------------------------------------------
module ugbp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] num,
	input  logic [30:0] den,
	output logic        done,
	output logic [32:0] quo,
	output logic        rem_nz
);

	logic [30:0] rem_q;
	logic [32:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] trial;
	logic        ge;

	assign trial = {rem_q, quo_q[32]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(ugbp_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? 31'(trial - {1'b0, den}) : trial[30:0];
			quo_q <= {quo_q[31:0], ge};
		end
	end

	assign done   = done_q;
	assign quo    = quo_q;
	assign rem_nz = |rem_q;

endmodule

FILE: hw/rtl/ugbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugbp_ctrl
// Sequencer: divisions, memory sweep, cell walk, bit scan and final word.
// ----------------------------------------------------------------------------
module ugbp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ugbp_pkg::sts_t sts,
	output ugbp_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		S_INIT  = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_DIVGO = 11'b000_0000_0100,
		S_DIVW  = 11'b000_0000_1000,
		S_POST  = 11'b000_0001_0000,
		S_SWEEP = 11'b000_0010_0000,
		S_RD    = 11'b000_0100_0000,
		S_USE   = 11'b000_1000_0000,
		S_SCAN  = 11'b001_0000_0000,
		S_NEXT  = 11'b010_0000_0000,
		S_FINAL = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.in_refuse ? S_FINAL : S_DIVGO;
				end
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (sts.div_done) begin
					cmd.div_next = 1'b1;
					state_d      = sts.div_last ? S_POST : S_DIVGO;
				end
			end
			S_POST: begin
				cmd.post = 1'b1;
				if (sts.req == ugbp_pkg::REQ_CLEAR)
					state_d = S_SWEEP;
				else if (sts.req == ugbp_pkg::REQ_INSERT && sts.loop_empty)
					state_d = S_FINAL;
				else
					state_d = S_RD;
			end
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last)
					state_d = S_FINAL;
			end
			S_RD: begin
				if (sts.in_grid) begin
					cmd.rd  = 1'b1;
					state_d = S_USE;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_USE: begin
				if (sts.req == ugbp_pkg::REQ_INSERT) begin
					cmd.ins_wr = 1'b1;
					state_d    = S_NEXT;
				end else begin
					cmd.scan_load = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_empty)
					state_d = S_NEXT;
				else if (!sts.pend_v || sts.out_free)
					cmd.scan_step = 1'b1;
			end
			S_NEXT: begin
				cmd.loop_next = 1'b1;
				state_d       = sts.loop_last ? S_FINAL : S_RD;
			end
			S_FINAL: begin
				if (sts.out_free) begin
					cmd.final_push = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_INIT;
		else
			state_q <= state_d;
	end

	// a new word is only taken while nothing is in flight
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> state_q == S_IDLE)
		else $error("accept outside idle");

	a_final_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.final_push |-> sts.out_free)
		else $error("final word pushed into full output");

	a_scan_safe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step && sts.pend_v |-> sts.out_free)
		else $error("pending word overwritten");

endmodule

FILE: hw/rtl/ugbp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugbp_dp
// Datapath: config registers, divider, cell mask memory, walk and output.
// ----------------------------------------------------------------------------
module ugbp_dp #(
	parameter int GRID_X      = 16,
	parameter int GRID_Z      = 16,
	parameter int MAX_VOLUMES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ugbp_pkg::cmd_t        cmd,
	output ugbp_pkg::sts_t        sts,
	input  logic [1:0]            req_type,
	input  logic signed [31:0]    vol_min_x,
	input  logic signed [31:0]    vol_max_x,
	input  logic signed [31:0]    vol_min_z,
	input  logic signed [31:0]    vol_max_z,
	input  logic signed [31:0]    point_x,
	input  logic signed [31:0]    point_z,
	input  logic [2:0]            near_range,
	input  logic                  cfg_valid,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [5:0]            volume_index,
	output logic                  hit,
	output logic                  status,
	output logic                  last
);

	localparam int CW    = ugbp_pkg::CW;
	localparam int IW    = ugbp_pkg::IDX_W;
	localparam int DEPTH = GRID_X * GRID_Z;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = $clog2(GRID_X + 1);
	localparam int ZW    = $clog2(GRID_Z + 1);
	localparam int VW    = $clog2(MAX_VOLUMES + 1);
	localparam int MW    = MAX_VOLUMES;

	function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	// configuration
	logic signed [31:0] wmnx_q, wmxx_q, wmnz_q, wmxz_q;
	logic [30:0]        chunk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmnx_q  <= ugbp_pkg::WMIN_RST;
			wmxx_q  <= ugbp_pkg::WMAX_RST;
			wmnz_q  <= ugbp_pkg::WMIN_RST;
			wmxz_q  <= ugbp_pkg::WMAX_RST;
			chunk_q <= ugbp_pkg::CHUNK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ugbp_pkg::CFG_WMIN_X: wmnx_q  <= cfg_data;
				ugbp_pkg::CFG_WMAX_X: wmxx_q  <= cfg_data;
				ugbp_pkg::CFG_WMIN_Z: wmnz_q  <= cfg_data;
				ugbp_pkg::CFG_WMAX_Z: wmxz_q  <= cfg_data;
				ugbp_pkg::CFG_CHUNK:  chunk_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// latched request word
	ugbp_pkg::req_t     req_q;
	logic               refuse_q;
	logic signed [31:0] vmnx_q, vmxx_q, vmnz_q, vmxz_q, px_q, pz_q;
	logic [2:0]         range_q;
	logic [VW-1:0]      vcount_q;
	logic               full;

	assign full = vcount_q >= VW'(MAX_VOLUMES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q    <= ugbp_pkg::REQ_CLEAR;
			refuse_q <= 1'b0;
		end else if (cmd.accept) begin
			req_q    <= ugbp_pkg::req_t'(req_type);
			refuse_q <= (req_type == ugbp_pkg::REQ_INSERT) && full;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			vmnx_q  <= vol_min_x;
			vmxx_q  <= vol_max_x;
			vmnz_q  <= vol_min_z;
			vmxz_q  <= vol_max_z;
			px_q    <= point_x;
			pz_q    <= point_z;
			range_q <= near_range;
		end
	end

	// division operands
	logic [1:0]         k_q;
	logic signed [31:0] opa, opb;
	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic               is_clr, neg;

	always_comb begin
		opa = '0;
		opb = '0;
		case (req_q)
			ugbp_pkg::REQ_CLEAR: begin
				opa = k_q[0] ? wmxz_q : wmxx_q;
				opb = k_q[0] ? wmnz_q : wmnx_q;
			end
			ugbp_pkg::REQ_INSERT: begin
				case (k_q)
					2'd0: begin
						opa = (vmnx_q < wmnx_q) ? wmnx_q : vmnx_q;
						opb = wmnx_q;
					end
					2'd1: begin
						opa = (vmxx_q > wmxx_q) ? wmxx_q : vmxx_q;
						opb = wmnx_q;
					end
					2'd2: begin
						opa = (vmnz_q < wmnz_q) ? wmnz_q : vmnz_q;
						opb = wmnz_q;
					end
					default: begin
						opa = (vmxz_q > wmxz_q) ? wmxz_q : vmxz_q;
						opb = wmnz_q;
					end
				endcase
			end
			default: begin
				opa = k_q[0] ? pz_q : px_q;
				opb = k_q[0] ? wmnz_q : wmnx_q;
			end
		endcase
		diff   = 33'(opa) - 33'(opb);
		is_clr = req_q == ugbp_pkg::REQ_CLEAR;
		neg    = diff[32];
		// an empty or inverted extent counts as zero cells, clamped to one later
		if (neg)
			mag = is_clr ? '0 : 33'(-diff);
		else
			mag = 33'(diff);
	end

	logic        neg_q, adj_q;
	logic        div_done, rem_nz;
	logic [32:0] quo;
	logic [30:0] den;

	assign den = (chunk_q == '0) ? 31'd1 : chunk_q;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= neg && !is_clr;
			adj_q <= neg || is_clr;
		end
	end

	ugbp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (mag),
		.den    (den),
		.done   (div_done),
		.quo    (quo),
		.rem_nz (rem_nz)
	);

	// floor for negative offsets, ceiling for cell counts
	logic [34:0]          qsum;
	logic signed [34:0]   qval;
	logic signed [CW-1:0] r_q [4];
	logic                 div_last;

	assign qsum     = {2'b00, quo} + 35'(adj_q && rem_nz);
	assign qval     = neg_q ? -$signed(qsum) : $signed(qsum);
	assign div_last = (req_q == ugbp_pkg::REQ_INSERT) ? (k_q == 2'd3) : (k_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			k_q <= '0;
		else if (cmd.div_next)
			k_q <= div_last ? 2'd0 : k_q + 2'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_next)
			r_q[k_q] <= ugbp_pkg::sat_cell(qval);
	end

	// grid extents and walk bounds
	logic [XW-1:0]        cax_q;
	logic [ZW-1:0]        caz_q;
	logic signed [CW-1:0] cax_s, caz_s, rng_s;
	logic signed [CW-1:0] xlo_d, xhi_d, zlo_d, zhi_d;
	logic signed [CW-1:0] x_q, z_q, xlo_q, xhi_q, zhi_q;
	logic                 empty_d, in_grid, loop_last;

	assign cax_s = $signed({{(CW-XW){1'b0}}, cax_q});
	assign caz_s = $signed({{(CW-ZW){1'b0}}, caz_q});
	assign rng_s = $signed({{(CW-3){1'b0}}, range_q});

	always_comb begin
		case (req_q)
			ugbp_pkg::REQ_INSERT: begin
				xlo_d = smax(r_q[0], '0);
				xhi_d = smin(r_q[1], cax_s - CW'(1));
				zlo_d = smax(r_q[2], '0);
				zhi_d = smin(r_q[3], caz_s - CW'(1));
			end
			ugbp_pkg::REQ_QCELL: begin
				xlo_d = smin(smax(r_q[0], '0), cax_s - CW'(1));
				xhi_d = xlo_d;
				zlo_d = smin(smax(r_q[1], '0), caz_s - CW'(1));
				zhi_d = zlo_d;
			end
			default: begin
				xlo_d = r_q[0] - rng_s;
				xhi_d = r_q[0] + rng_s;
				zlo_d = r_q[1] - rng_s;
				zhi_d = r_q[1] + rng_s;
			end
		endcase
		empty_d = (xlo_d > xhi_d) || (zlo_d > zhi_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cax_q <= XW'(1);
			caz_q <= ZW'(1);
		end else if (cmd.post && req_q == ugbp_pkg::REQ_CLEAR) begin
			cax_q <= (r_q[0] < 1) ? XW'(1) : (r_q[0] > GRID_X) ? XW'(GRID_X) : XW'(r_q[0]);
			caz_q <= (r_q[1] < 1) ? ZW'(1) : (r_q[1] > GRID_Z) ? ZW'(GRID_Z) : ZW'(r_q[1]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			x_q   <= xlo_d;
			z_q   <= zlo_d;
			xlo_q <= xlo_d;
			xhi_q <= xhi_d;
			zhi_q <= zhi_d;
		end else if (cmd.loop_next) begin
			if (x_q == xhi_q) begin
				x_q <= xlo_q;
				z_q <= z_q + CW'(1);
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
	end

	assign in_grid   = !x_q[CW-1] && (x_q < cax_s) && !z_q[CW-1] && (z_q < caz_s);
	assign loop_last = (x_q == xhi_q) && (z_q == zhi_q);

	// cell mask memory
	logic [AW-1:0] sweep_q, addr;
	logic          sweep_last, we;
	logic [MW-1:0] mem_q [DEPTH];
	logic [MW-1:0] rdata_q, wdata, vbit;

	assign sweep_last = sweep_q == AW'(DEPTH - 1);
	assign vbit       = MW'(1) << vcount_q;
	assign we         = cmd.sweep_step || cmd.ins_wr;
	assign wdata      = cmd.sweep_step ? '0 : (rdata_q | vbit);
	assign addr       = cmd.sweep_step ? sweep_q :
		AW'(32'(z_q[CW-2:0]) * GRID_X + 32'(x_q[CW-2:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sweep_q <= '0;
		else if (cmd.sweep_step)
			sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		if (cmd.rd)
			rdata_q <= mem_q[addr];
	end

	// bit scan
	logic [MW-1:0] scan_q, seen_q, low_bit;
	logic [IW-1:0] low_idx, pend_q;
	logic          pend_v_q;

	always_comb begin
		low_idx = '0;
		for (int i = MW - 1; i >= 0; i--)
			if (scan_q[i])
				low_idx = IW'(i);
	end

	assign low_bit = scan_q & (~scan_q + MW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			seen_q   <= '0;
			pend_v_q <= 1'b0;
			vcount_q <= '0;
		end else begin
			if (cmd.post && req_q == ugbp_pkg::REQ_CLEAR)
				vcount_q <= '0;
			else if (cmd.final_push && req_q == ugbp_pkg::REQ_INSERT && !refuse_q)
				vcount_q <= vcount_q + VW'(1);
			if (cmd.post) begin
				seen_q   <= '0;
				pend_v_q <= 1'b0;
			end else if (cmd.scan_step) begin
				seen_q   <= seen_q | low_bit;
				pend_v_q <= 1'b1;
			end
			if (cmd.scan_load)
				scan_q <= rdata_q & ~seen_q;
			else if (cmd.scan_step)
				scan_q <= scan_q & ~low_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step)
			pend_q <= low_idx;
	end

	// output word register
	logic          out_v_q, out_free, push;
	logic [IW-1:0] o_idx_q, f_idx;
	logic          o_hit_q, o_st_q, o_last_q, f_hit, f_st;

	assign out_free = !out_v_q || out_ready;
	assign push     = cmd.final_push || (cmd.scan_step && pend_v_q);

	always_comb begin
		f_idx = '0;
		f_hit = 1'b0;
		f_st  = 1'b0;
		case (req_q)
			ugbp_pkg::REQ_CLEAR: ;
			ugbp_pkg::REQ_INSERT: begin
				if (refuse_q) begin
					f_st = 1'b1;
				end else begin
					f_idx = IW'(vcount_q);
					f_hit = 1'b1;
				end
			end
			default: begin
				f_idx = pend_v_q ? pend_q : '0;
				f_hit = pend_v_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (push)
			out_v_q <= 1'b1;
		else if (out_ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			o_idx_q  <= cmd.final_push ? f_idx : pend_q;
			o_hit_q  <= cmd.final_push ? f_hit : 1'b1;
			o_st_q   <= cmd.final_push ? f_st : 1'b0;
			o_last_q <= cmd.final_push;
		end
	end

	assign out_valid    = out_v_q;
	assign volume_index = o_idx_q;
	assign hit          = o_hit_q;
	assign status       = o_st_q;
	assign last         = o_last_q;

	always_comb begin
		sts            = '0;
		sts.req        = req_q;
		sts.in_refuse  = (req_type == ugbp_pkg::REQ_INSERT) && full;
		sts.div_done   = div_done;
		sts.div_last   = div_last;
		sts.sweep_last = sweep_last;
		sts.loop_empty = empty_d;
		sts.in_grid    = in_grid;
		sts.scan_empty = scan_q == '0;
		sts.out_free   = out_free;
		sts.pend_v     = pend_v_q;
		sts.loop_last  = loop_last;
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= VW'(MAX_VOLUMES))
		else $error("volume count over capacity");

	a_scan_unseen: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_q & seen_q) == '0)
		else $error("scan holds an emitted volume");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("output word lost");

endmodule

FILE: hw/rtl/uniform_grid_broad_phase_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_broad_phase_top
// 2D uniform grid broad phase over XZ, Q16.16 coordinates, per-cell masks.
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       in         in_valid / in_ready     req_type, vol_*, point_*, near_range
// out      out        out_valid / out_ready   volume_index, hit, status, last
// cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item at a time: each division runs on the bit-serial divider (two for
// clear and queries, four for insert). Clear then sweeps the memory; insert
// visits each covered cell in RD, USE, NEXT; a query visits each grid cell in
// RD, USE, SCAN, NEXT with one scan step per word found, each window cell off
// the grid in RD, NEXT. After reset the memory is swept once before in_ready.
// Stalls on out_ready hold the walk; one finished word may wait in the output.
// ----------------------------------------------------------------------------
module uniform_grid_broad_phase_top #(
	parameter int GRID_X      = 16,
	parameter int GRID_Z      = 16,
	parameter int MAX_VOLUMES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] vol_min_x,
	input  logic signed [31:0] vol_max_x,
	input  logic signed [31:0] vol_min_z,
	input  logic signed [31:0] vol_max_z,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_z,
	input  logic [2:0]         near_range,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         volume_index,
	output logic               hit,
	output logic               status,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	ugbp_pkg::cmd_t cmd;
	ugbp_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ugbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ugbp_dp #(
		.GRID_X      (GRID_X),
		.GRID_Z      (GRID_Z),
		.MAX_VOLUMES (MAX_VOLUMES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.vol_min_x    (vol_min_x),
		.vol_max_x    (vol_max_x),
		.vol_min_z    (vol_min_z),
		.vol_max_z    (vol_max_z),
		.point_x      (point_x),
		.point_z      (point_z),
		.near_range   (near_range),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.volume_index (volume_index),
		.hit          (hit),
		.status       (status),
		.last         (last)
	);

endmodule
